FILE: sv/erot_pkg.sv
// Shared types, constants and tables of the Euler Z-Y-X vector rotator.
`default_nettype none
package erot_pkg;

  typedef logic signed [17:0] coef_t;
  typedef coef_t [8:0] coef_mat_t;
  typedef coef_t [5:0] fac_vec_t;
  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_YAW   = 2'd0;
  localparam reg_idx_t REG_PITCH = 2'd1;
  localparam reg_idx_t REG_ROLL  = 2'd2;

  localparam int ZW = 36;
  localparam int XW = 34;
  localparam int MAX_STAGES = 24;

  localparam logic signed [XW-1:0] ANG_GAIN    = 34'sd652032874;
  localparam logic signed [ZW-1:0] ANG_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] ANG_HALF_PI = 36'sd1686629713;
  localparam logic signed [ZW-1:0] ANG_TWO_PI  = 36'sd6746518852;

  localparam coef_t ONE_Q16  = 18'sd65536;
  localparam coef_t COEF_MAX = 18'sd131071;
  localparam coef_t COEF_MIN = -18'sd131072;

  typedef enum logic [2:0] {
    F_SA, F_CA, F_SB, F_CB, F_SG, F_CG, F_ONE, F_ZERO
  } fac_e;

  typedef struct packed {
    fac_e a1;
    fac_e a2;
    fac_e a3;
    fac_e b1;
    fac_e b2;
    logic a_neg;
    logic b_neg;
  } recipe_t;

  typedef struct packed {
    logic  done;
    coef_t sin_v;
    coef_t cos_v;
  } trig_res_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h3243F6A8;
      5'd1:  r = 32'h1DAC6705;
      5'd2:  r = 32'h0FADBAFC;
      5'd3:  r = 32'h07F56EA6;
      5'd4:  r = 32'h03FEAB76;
      5'd5:  r = 32'h01FFD55B;
      5'd6:  r = 32'h00FFFAAA;
      5'd7:  r = 32'h007FFF55;
      5'd8:  r = 32'h003FFFEA;
      5'd9:  r = 32'h001FFFFD;
      5'd10: r = 32'h000FFFFF;
      5'd11: r = 32'h0007FFFF;
      5'd12: r = 32'h0003FFFF;
      5'd13: r = 32'h0001FFFF;
      5'd14: r = 32'h0000FFFF;
      5'd15: r = 32'h00007FFF;
      5'd16: r = 32'h00003FFF;
      5'd17: r = 32'h00001FFF;
      5'd18: r = 32'h00000FFF;
      5'd19: r = 32'h000007FF;
      5'd20: r = 32'h000003FF;
      5'd21: r = 32'h000001FF;
      5'd22: r = 32'h000000FF;
      5'd23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // Each coefficient is a1*a2*a3 plus b1*b2 scaled by one, either term negated.
  function automatic recipe_t coef_recipe(input logic [3:0] k);
    recipe_t r;
    case (k)
      4'd0: r = '{F_CA, F_CB, F_ONE, F_ZERO, F_ZERO, 1'b0, 1'b0};
      4'd1: r = '{F_CA, F_SB, F_SG, F_SA, F_CG, 1'b0, 1'b1};
      4'd2: r = '{F_CA, F_SB, F_CG, F_SA, F_SG, 1'b0, 1'b0};
      4'd3: r = '{F_SA, F_CB, F_ONE, F_ZERO, F_ZERO, 1'b0, 1'b0};
      4'd4: r = '{F_SA, F_SB, F_SG, F_CA, F_CG, 1'b0, 1'b0};
      4'd5: r = '{F_SA, F_SB, F_CG, F_CA, F_SG, 1'b0, 1'b1};
      4'd6: r = '{F_SB, F_ONE, F_ONE, F_ZERO, F_ZERO, 1'b1, 1'b0};
      4'd7: r = '{F_CB, F_SG, F_ONE, F_ZERO, F_ZERO, 1'b0, 1'b0};
      4'd8: r = '{F_CB, F_CG, F_ONE, F_ZERO, F_ZERO, 1'b0, 1'b0};
      default: r = '{F_ZERO, F_ZERO, F_ZERO, F_ZERO, F_ZERO, 1'b0, 1'b0};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/erot_if.sv
// Channel interfaces of the rotator: vector input, result output and register writes.
`default_nettype none
interface erot_vec_if #(parameter int DATA_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] in_x;
  logic signed [DATA_WIDTH-1:0] in_y;
  logic signed [DATA_WIDTH-1:0] in_z;
  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

interface erot_res_if #(parameter int DATA_WIDTH = 24);
  logic valid;
  logic ready;
  logic signed [DATA_WIDTH-1:0] out_x;
  logic signed [DATA_WIDTH-1:0] out_y;
  logic signed [DATA_WIDTH-1:0] out_z;
  logic saturated;
  modport source (output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink (input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

interface erot_cfg_if;
  logic valid;
  logic ready;
  erot_pkg::reg_idx_t index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/euler_zyx_vector_rotator.sv
// Top level of the Euler Z-Y-X vector rotator.
//
// Usage: yaw, pitch and roll angles (signed radians times 4096) are written on
// the configuration channel, index 0, 1 and 2; other indexes are ignored. Each
// write rebuilds the nine Q1.16 matrix coefficients with one shared CORDIC
// unit and one multiplier chain; no vector and no further write is taken
// meanwhile, nor while a write waits on the configuration channel.
// Vectors enter on in_i and leave rotated on out_o, with each component
// rounded and saturated to DATA_WIDTH bits and a flag for any clipping.
// The datapath is a three-stage pipeline (products, row sums, round and
// saturate), each stage registered: one vector per cycle while no write is
// pending or under way. When the receiver stalls, the whole pipeline holds and
// in_i.ready drops; nothing is lost or repeated. Reset clears the angles to
// zero and loads the exact identity matrix.
`default_nettype none
module euler_zyx_vector_rotator #(
  parameter int DATA_WIDTH  = 24,
  parameter int TRIG_STAGES = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  erot_cfg_if.sink   cfg_i,
  erot_vec_if.sink   in_i,
  erot_res_if.source out_o
);
  import erot_pkg::*;

  coef_mat_t coef;
  logic busy;

  erot_coef #(.TRIG_STAGES(TRIG_STAGES)) u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .coef_o (coef),
    .busy_o (busy)
  );

  erot_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (coef),
    .busy_i (busy),
    .hold_i (cfg_i.valid),
    .in_i   (in_i),
    .out_o  (out_o)
  );

endmodule
`default_nettype wire

FILE: sv/erot_trig.sv
// Iterative CORDIC unit giving sine and cosine of one angle in Q1.16.
`default_nettype none
module erot_trig #(
  parameter int TRIG_STAGES = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start_i,
  input  wire  signed [15:0]  angle_i,
  output erot_pkg::trig_res_t res_o
);
  import erot_pkg::*;

  localparam int N  = (TRIG_STAGES > MAX_STAGES) ? MAX_STAGES : TRIG_STAGES;
  localparam int CW = $clog2(N);

  typedef enum logic [1:0] {T_IDLE, T_FOLD, T_ITER, T_DONE} tstate_e;

  tstate_e state_q;
  logic [CW-1:0] i_q;
  logic signed [ZW-1:0] z_q;
  logic signed [XW-1:0] x_q, y_q;
  logic neg_q;

  logic signed [ZW-1:0] z_in, z_wrap, atan_v;
  logic signed [XW-1:0] dx, dy, xf, yf, xr, yr;

  always_comb begin
    z_in = {{(ZW-34){angle_i[15]}}, angle_i, 18'b0};
    if (z_in > ANG_PI) begin
      z_wrap = z_in - ANG_TWO_PI;
    end else if (z_in < -ANG_PI) begin
      z_wrap = z_in + ANG_TWO_PI;
    end else begin
      z_wrap = z_in;
    end
    atan_v = ZW'(signed'({1'b0, atan_lut(5'(i_q))}));
    dx = y_q >>> i_q;
    dy = x_q >>> i_q;
    xf = neg_q ? -x_q : x_q;
    yf = neg_q ? -y_q : y_q;
    xr = (xf + XW'(8192)) >>> 14;
    yr = (yf + XW'(8192)) >>> 14;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      i_q     <= '0;
    end else begin
      case (state_q)
        T_IDLE: if (start_i) state_q <= T_FOLD;
        T_FOLD: begin
          state_q <= T_ITER;
          i_q     <= '0;
        end
        T_ITER: begin
          if (i_q == CW'(N - 1)) begin
            state_q <= T_DONE;
          end
          i_q <= i_q + 1'b1;
        end
        T_DONE: state_q <= T_IDLE;
        default: state_q <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      T_IDLE: begin
        if (start_i) begin
          z_q   <= z_wrap;
          x_q   <= ANG_GAIN;
          y_q   <= '0;
          neg_q <= 1'b0;
        end
      end
      T_FOLD: begin
        if (z_q > ANG_HALF_PI) begin
          z_q   <= z_q - ANG_PI;
          neg_q <= 1'b1;
        end else if (z_q < -ANG_HALF_PI) begin
          z_q   <= z_q + ANG_PI;
          neg_q <= 1'b1;
        end
      end
      T_ITER: begin
        if (!z_q[ZW-1]) begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + atan_v;
        end
      end
      default: ;
    endcase
  end

  assign res_o.done  = (state_q == T_DONE);
  assign res_o.cos_v = xr[17:0];
  assign res_o.sin_v = yr[17:0];

endmodule
`default_nettype wire

FILE: sv/erot_coef.sv
// Angle registers and sequencer that rebuilds the rotation matrix after each angle write.
`default_nettype none
module erot_coef #(
  parameter int TRIG_STAGES = 16
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  erot_cfg_if.sink            cfg_i,
  output erot_pkg::coef_mat_t coef_o,
  output logic                busy_o
);
  import erot_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_TSTART, S_TWAIT, S_MUL1, S_MUL2, S_ACC} sstate_e;

  sstate_e state_q;
  logic signed [15:0] ang_q [3];
  logic [1:0] ai_q;
  logic [3:0] k_q;
  coef_mat_t coef_q;
  fac_vec_t sc_q;
  logic signed [35:0] p_q, q_q;
  logic signed [53:0] t_q;

  trig_res_t trig;
  recipe_t rc;
  logic signed [55:0] va, vb, vs;
  logic signed [23:0] vr;
  coef_t vsat;
  logic cfg_hit;

  function automatic coef_t fac(input fac_e f, input fac_vec_t v);
    coef_t r;
    case (f)
      F_SA:   r = v[0];
      F_CA:   r = v[1];
      F_SB:   r = v[2];
      F_CB:   r = v[3];
      F_SG:   r = v[4];
      F_CG:   r = v[5];
      F_ONE:  r = ONE_Q16;
      F_ZERO: r = '0;
      default: r = '0;
    endcase
    return r;
  endfunction

  erot_trig #(.TRIG_STAGES(TRIG_STAGES)) u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_TSTART),
    .angle_i (ang_q[ai_q]),
    .res_o   (trig)
  );

  assign cfg_i.ready = (state_q == S_IDLE);
  assign cfg_hit = cfg_i.valid && cfg_i.ready;
  assign busy_o = (state_q != S_IDLE);
  assign coef_o = coef_q;

  always_comb begin
    rc = coef_recipe(k_q);
    va = rc.a_neg ? -56'(t_q) : 56'(t_q);
    vb = 56'(q_q) <<< 16;
    if (rc.b_neg) begin
      vb = -vb;
    end
    vs = ((va + vb) + 56'sd2147483648) >>> 32;
    vr = vs[23:0];
    if (vr > 24'(COEF_MAX)) begin
      vsat = COEF_MAX;
    end else if (vr < 24'(COEF_MIN)) begin
      vsat = COEF_MIN;
    end else begin
      vsat = vr[17:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ai_q    <= '0;
      k_q     <= '0;
      ang_q   <= '{default: '0};
      for (int n = 0; n < 9; n++) begin
        coef_q[n] <= (n % 4 == 0) ? ONE_Q16 : '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cfg_hit && (cfg_i.index == REG_YAW || cfg_i.index == REG_PITCH ||
                          cfg_i.index == REG_ROLL)) begin
            ang_q[cfg_i.index] <= cfg_i.data;
            ai_q    <= REG_YAW;
            state_q <= S_TSTART;
          end
        end
        S_TSTART: state_q <= S_TWAIT;
        S_TWAIT: begin
          if (trig.done) begin
            if (ai_q == REG_ROLL) begin
              k_q     <= '0;
              state_q <= S_MUL1;
            end else begin
              ai_q    <= ai_q + 1'b1;
              state_q <= S_TSTART;
            end
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_ACC;
        S_ACC: begin
          coef_q[k_q] <= vsat;
          if (k_q == 4'd8) begin
            state_q <= S_IDLE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_MUL1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_TWAIT && trig.done) begin
      sc_q[{ai_q, 1'b0}]        <= trig.sin_v;
      sc_q[{ai_q, 1'b0} + 3'd1] <= trig.cos_v;
    end
    if (state_q == S_MUL1) begin
      p_q <= 36'(fac(rc.a1, sc_q)) * 36'(fac(rc.a2, sc_q));
      q_q <= 36'(fac(rc.b1, sc_q)) * 36'(fac(rc.b2, sc_q));
    end
    if (state_q == S_MUL2) begin
      t_q <= 54'(p_q) * 54'(fac(rc.a3, sc_q));
    end
  end

endmodule
`default_nettype wire

FILE: sv/erot_mac.sv
// Three-stage pipeline that multiplies each vector by the coefficient matrix.
`default_nettype none
module erot_mac #(
  parameter int DATA_WIDTH = 24
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  erot_pkg::coef_mat_t coef_i,
  input  wire                 busy_i,
  input  wire                 hold_i,
  erot_vec_if.sink            in_i,
  erot_res_if.source          out_o
);
  import erot_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int EW  = DW + 16;
  localparam int PHW = DW + 18;
  localparam int PLW = 35;
  localparam int SHW = DW + 20;
  localparam int SLW = 37;
  localparam int RW  = SHW + 1;
  localparam logic signed [RW-1:0] MAXV = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [RW-1:0] MINV = ~MAXV;

  logic v1_q, v2_q, v3_q;
  logic signed [PHW-1:0] ph_q [9];
  logic signed [PLW-1:0] pl_q [9];
  logic signed [SHW-1:0] sh_q [3];
  logic signed [SLW-1:0] sl_q [3];
  logic signed [DW-1:0] o_q [3];
  logic sat_q;

  logic adv;
  logic signed [DW-1:0] vin [3];
  logic signed [EW-1:0] ext [3];
  logic signed [DW-1:0] hi [3];
  logic signed [16:0] lo [3];
  logic signed [PHW-1:0] ph [9];
  logic signed [PLW-1:0] pl [9];
  logic signed [SHW-1:0] sh [3];
  logic signed [SLW-1:0] sl [3];
  logic signed [SLW:0] slr [3];
  logic signed [RW-1:0] res [3];
  logic signed [DW-1:0] o [3];
  logic [2:0] clip;

  assign adv = !v3_q || out_o.ready;
  assign in_i.ready = adv && !busy_i && !hold_i;

  always_comb begin
    vin[0] = in_i.in_x;
    vin[1] = in_i.in_y;
    vin[2] = in_i.in_z;
    for (int j = 0; j < 3; j++) begin
      ext[j] = EW'(vin[j]);
      hi[j]  = ext[j][EW-1:16];
      lo[j]  = {1'b0, ext[j][15:0]};
    end
    for (int n = 0; n < 9; n++) begin
      ph[n] = PHW'(coef_i[n]) * PHW'(hi[n % 3]);
      pl[n] = PLW'(coef_i[n]) * PLW'(lo[n % 3]);
    end
    for (int r = 0; r < 3; r++) begin
      sh[r] = SHW'(ph_q[3*r]) + SHW'(ph_q[3*r+1]) + SHW'(ph_q[3*r+2]);
      sl[r] = SLW'(pl_q[3*r]) + SLW'(pl_q[3*r+1]) + SLW'(pl_q[3*r+2]);
      slr[r] = ((SLW+1)'(sl_q[r]) + (SLW+1)'(32768)) >>> 16;
      res[r] = RW'(sh_q[r]) + RW'(slr[r]);
      clip[r] = (res[r] > MAXV) || (res[r] < MINV);
      if (res[r] > MAXV) begin
        o[r] = MAXV[DW-1:0];
      end else if (res[r] < MINV) begin
        o[r] = MINV[DW-1:0];
      end else begin
        o[r] = res[r][DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid && in_i.ready;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ph_q <= ph;
      pl_q <= pl;
      sh_q <= sh;
      sl_q <= sl;
      o_q  <= o;
      sat_q <= |clip;
    end
  end

  assign out_o.valid     = v3_q;
  assign out_o.out_x     = o_q[0];
  assign out_o.out_y     = o_q[1];
  assign out_o.out_z     = o_q[2];
  assign out_o.saturated = sat_q;

endmodule
`default_nettype wire
